/* hw/rtl/hpd_pkg.sv */
// shared types, constants and the per-level curve step for the hilbert pair distance block
`timescale 1ns / 1ps

package hpd_pkg;

  localparam int unsigned MAX_ORDER = 16;
  localparam int unsigned ORDER_W   = 5;
  localparam int unsigned IDX_W     = 33;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned SUM_W     = SQ_W + 1;
  localparam int unsigned M_W       = 40;
  localparam int unsigned ROOT_W    = M_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned DIST_W    = 20;
  localparam int unsigned MAP_CELLS = MAX_ORDER;
  localparam int unsigned SQ_CELLS  = ROOT_W;
  localparam int unsigned SCALE     = 100;
  localparam int unsigned DIST_MAX  = 926819;

  localparam logic [1:0] QUAD_LL = 2'd0;
  localparam logic [1:0] QUAD_UL = 2'd1;
  localparam logic [1:0] QUAD_UR = 2'd2;
  localparam logic [1:0] QUAD_LR = 2'd3;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
  } hpd_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [DIST_W-1:0]  scaled_distance;
    logic               range_error;
  } hpd_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } hpd_pt_t;

  typedef struct packed {
    hpd_pt_t a;
    hpd_pt_t b;
    logic    err;
  } hpd_side_t;

  typedef struct packed {
    logic [ORDER_W-1:0] lvl;
    logic [COORD_W-1:0] half;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    hpd_side_t          side;
  } hpd_map_t;

  typedef struct packed {
    logic [M_W-1:0]    m;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    hpd_side_t         side;
  } hpd_sqrt_t;

  function automatic hpd_pt_t quad_step(hpd_pt_t p, logic [COORD_W-1:0] half,
                                        logic [1:0] quad);
    hpd_pt_t            r;
    logic [COORD_W:0]   side2;
    logic [COORD_W-1:0] full;
    side2 = {half, 1'b0} - (COORD_W+1)'(1);
    full  = side2[COORD_W-1:0];
    unique case (quad)
      QUAD_LL: begin
        r.x = p.y;
        r.y = p.x;
      end
      QUAD_UL: begin
        r.x = p.x;
        r.y = p.y + half;
      end
      QUAD_UR: begin
        r.x = p.x + half;
        r.y = p.y + half;
      end
      default: begin
        r.x = full - p.y;
        r.y = half - COORD_W'(1) - p.x;
      end
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/hpd_map_cell.sv */
// one curve level: maps the next base-4 digit of both positions
`timescale 1ns / 1ps

module hpd_map_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  hpd_pkg::hpd_map_t in_cell,
  output logic              out_vld,
  output hpd_pkg::hpd_map_t out_cell
);

  logic              vld_r;
  hpd_pkg::hpd_map_t cell_r;
  hpd_pkg::hpd_map_t cell_nxt;
  logic              active;

  assign active = (in_cell.lvl != '0);

  always_comb begin
    cell_nxt       = in_cell;
    cell_nxt.half  = {in_cell.half[hpd_pkg::COORD_W-2:0], 1'b0};
    cell_nxt.pos_a = in_cell.pos_a >> 2;
    cell_nxt.pos_b = in_cell.pos_b >> 2;
    if (active) begin
      cell_nxt.lvl    = in_cell.lvl - hpd_pkg::ORDER_W'(1);
      cell_nxt.side.a = hpd_pkg::quad_step(in_cell.side.a, in_cell.half, in_cell.pos_a[1:0]);
      cell_nxt.side.b = hpd_pkg::quad_step(in_cell.side.b, in_cell.half, in_cell.pos_b[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule

/* hw/rtl/hpd_sqrt_cell.sv */
// one root bit of the digit-by-digit integer square root
`timescale 1ns / 1ps

module hpd_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  hpd_pkg::hpd_sqrt_t in_cell,
  output logic               out_vld,
  output hpd_pkg::hpd_sqrt_t out_cell
);

  localparam int unsigned CUR_W = hpd_pkg::REM_W + 2;

  logic               vld_r;
  hpd_pkg::hpd_sqrt_t cell_r;
  hpd_pkg::hpd_sqrt_t cell_nxt;
  logic [CUR_W-1:0]   cur;
  logic [CUR_W-1:0]   trial;
  logic [CUR_W-1:0]   diff;
  logic               ge;

  assign cur   = {in_cell.rem, in_cell.m[hpd_pkg::M_W-1 -: 2]};
  assign trial = CUR_W'({in_cell.root, 2'b01});
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_comb begin
    cell_nxt      = in_cell;
    cell_nxt.m    = in_cell.m << 2;
    cell_nxt.rem  = ge ? diff[hpd_pkg::REM_W-1:0] : cur[hpd_pkg::REM_W-1:0];
    cell_nxt.root = {in_cell.root[hpd_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule

/* hw/rtl/hilbert_pair_distance_top.sv */
// hilbert pair distance: maps two curve positions to points and their scaled distance
// stages from request to result: 1 check, 16 level cells, 4 arithmetic, 20 root cells, 1 out
// throughput: one request per cycle; the whole chain holds while a result waits to be taken
// the 16 level cells and the 20 root-bit cells make up most of the pipeline, each cell one register stage
// reset: synchronous active-low rst_n clears the valid bits of every stage and the output
`timescale 1ns / 1ps

module hilbert_pair_distance_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hpd_pkg::hpd_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hpd_pkg::hpd_out_t out_data
);

  localparam int unsigned LIM_W = hpd_pkg::IDX_W + 1;

  logic adv;

  logic                            map_v [0:hpd_pkg::MAP_CELLS];
  hpd_pkg::hpd_map_t               map_d [0:hpd_pkg::MAP_CELLS];
  logic                            sq_v  [0:hpd_pkg::SQ_CELLS];
  hpd_pkg::hpd_sqrt_t              sq_d  [0:hpd_pkg::SQ_CELLS];

  logic                            front_v_r;
  hpd_pkg::hpd_map_t               front_r;
  hpd_pkg::hpd_map_t               front_nxt;
  logic [hpd_pkg::ORDER_W-1:0]     n_sat;
  logic [LIM_W-1:0]                limit;
  logic                            bad;
  logic [hpd_pkg::IDX_W-1:0]       pa;
  logic [hpd_pkg::IDX_W-1:0]       pb;

  logic                            diff_v_r;
  hpd_pkg::hpd_side_t              diff_side_r;
  logic [hpd_pkg::COORD_W-1:0]     dx_r;
  logic [hpd_pkg::COORD_W-1:0]     dy_r;
  logic [hpd_pkg::COORD_W-1:0]     dx_nxt;
  logic [hpd_pkg::COORD_W-1:0]     dy_nxt;
  hpd_pkg::hpd_side_t              map_last;

  logic                            sqr_v_r;
  hpd_pkg::hpd_side_t              sqr_side_r;
  logic [hpd_pkg::SQ_W-1:0]        sqx_r;
  logic [hpd_pkg::SQ_W-1:0]        sqy_r;

  logic                            sum_v_r;
  hpd_pkg::hpd_side_t              sum_side_r;
  logic [hpd_pkg::SUM_W-1:0]       sum_r;

  logic                            scl_v_r;
  hpd_pkg::hpd_sqrt_t              scl_r;

  logic                            out_valid_r;
  hpd_pkg::hpd_out_t               out_r;
  hpd_pkg::hpd_out_t               out_nxt;
  hpd_pkg::hpd_sqrt_t              sq_last;
  logic [hpd_pkg::ROOT_W-1:0]      dist_rnd;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // range check and chain setup
  always_comb begin
    n_sat = (in_data.order > hpd_pkg::ORDER_W'(hpd_pkg::MAX_ORDER)) ?
            hpd_pkg::ORDER_W'(hpd_pkg::MAX_ORDER) : in_data.order;
    limit = LIM_W'(1) << {n_sat, 1'b0};
    bad   = (in_data.first_index == '0) || (in_data.second_index == '0) ||
            ({1'b0, in_data.first_index} > limit) ||
            ({1'b0, in_data.second_index} > limit);
    pa    = in_data.first_index - hpd_pkg::IDX_W'(1);
    pb    = in_data.second_index - hpd_pkg::IDX_W'(1);
    front_nxt.lvl      = n_sat;
    front_nxt.half     = hpd_pkg::COORD_W'(1);
    front_nxt.pos_a    = pa[hpd_pkg::POS_W-1:0];
    front_nxt.pos_b    = pb[hpd_pkg::POS_W-1:0];
    front_nxt.side.a   = '0;
    front_nxt.side.b   = '0;
    front_nxt.side.err = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (adv) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_r <= front_nxt;
    end
  end

  assign map_v[0] = front_v_r;
  assign map_d[0] = front_r;

  for (genvar i = 0; i < hpd_pkg::MAP_CELLS; i++) begin : g_map
    hpd_map_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (map_v[i]),
      .in_cell  (map_d[i]),
      .out_vld  (map_v[i+1]),
      .out_cell (map_d[i+1])
    );
  end

  // coordinate differences
  assign map_last = map_d[hpd_pkg::MAP_CELLS].side;
  assign dx_nxt = (map_last.a.x >= map_last.b.x) ? (map_last.a.x - map_last.b.x) :
                                                   (map_last.b.x - map_last.a.x);
  assign dy_nxt = (map_last.a.y >= map_last.b.y) ? (map_last.a.y - map_last.b.y) :
                                                   (map_last.b.y - map_last.a.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_v_r <= 1'b0;
      sqr_v_r  <= 1'b0;
      sum_v_r  <= 1'b0;
      scl_v_r  <= 1'b0;
    end else if (adv) begin
      diff_v_r <= map_v[hpd_pkg::MAP_CELLS];
      sqr_v_r  <= diff_v_r;
      sum_v_r  <= sqr_v_r;
      scl_v_r  <= sum_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_side_r <= map_last;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      sqr_side_r  <= diff_side_r;
      sqx_r       <= hpd_pkg::SQ_W'(dx_r) * hpd_pkg::SQ_W'(dx_r);
      sqy_r       <= hpd_pkg::SQ_W'(dy_r) * hpd_pkg::SQ_W'(dy_r);
      sum_side_r  <= sqr_side_r;
      sum_r       <= hpd_pkg::SUM_W'(sqx_r) + hpd_pkg::SUM_W'(sqy_r);
      scl_r.m     <= hpd_pkg::M_W'(sum_r) * hpd_pkg::M_W'(hpd_pkg::SCALE);
      scl_r.rem   <= '0;
      scl_r.root  <= '0;
      scl_r.side  <= sum_side_r;
    end
  end

  assign sq_v[0] = scl_v_r;
  assign sq_d[0] = scl_r;

  for (genvar j = 0; j < hpd_pkg::SQ_CELLS; j++) begin : g_sqrt
    hpd_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (sq_v[j]),
      .in_cell  (sq_d[j]),
      .out_vld  (sq_v[j+1]),
      .out_cell (sq_d[j+1])
    );
  end

  // round to nearest and blank errored results
  assign sq_last = sq_d[hpd_pkg::SQ_CELLS];
  assign dist_rnd = (sq_last.rem > hpd_pkg::REM_W'(sq_last.root)) ?
                    (sq_last.root + hpd_pkg::ROOT_W'(1)) : sq_last.root;

  always_comb begin
    if (sq_last.side.err) begin
      out_nxt             = '0;
      out_nxt.range_error = 1'b1;
    end else begin
      out_nxt.first_x         = sq_last.side.a.x;
      out_nxt.first_y         = sq_last.side.a.y;
      out_nxt.second_x        = sq_last.side.b.x;
      out_nxt.second_y        = sq_last.side.b.y;
      out_nxt.scaled_distance = hpd_pkg::DIST_W'(dist_rnd);
      out_nxt.range_error     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_v[hpd_pkg::SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_levels_done: assert property (@(posedge clk) disable iff (!rst_n)
    map_v[hpd_pkg::MAP_CELLS] |-> (map_d[hpd_pkg::MAP_CELLS].lvl == '0))
    else $error("level cells left levels unmapped");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[hpd_pkg::SQ_CELLS] |->
      (sq_last.rem <= {1'b0, sq_last.root, 1'b0}))
    else $error("square root remainder out of bound");

  a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |->
      (out_data.first_x == '0 && out_data.first_y == '0 && out_data.second_x == '0 &&
       out_data.second_y == '0 && out_data.scaled_distance == '0))
    else $error("errored result carries nonzero fields");

  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.scaled_distance <= hpd_pkg::DIST_W'(hpd_pkg::DIST_MAX)))
    else $error("distance above largest grid diagonal");

endmodule

/* test/hilbert_pair_distance_top_test.sv */
// self-checking testbench for the hilbert pair distance block: directed corners, random traffic, backpressure
`timescale 1ns / 1ps

module hilbert_pair_distance_top_test;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned RANDOM_REQUESTS = 900;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_BURSTY,
    READY_MOSTLY
  } ready_mode_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  hpd_pkg::hpd_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  hpd_pkg::hpd_out_t out_data;

  hpd_pkg::hpd_out_t pending_geometry[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned mode_left = 0;

  hilbert_pair_distance_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // walk the curve levels from the finest quadrant up
  function automatic void curve_point(input logic [63:0] pos, input int unsigned n,
                                      output logic [63:0] px, output logic [63:0] py);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] nx;
    logic [63:0] ny;
    logic [63:0] half;
    logic [1:0]  quad;
    x = '0;
    y = '0;
    for (int k = 0; k < n; k++) begin
      half = 64'd1 << k;
      quad = pos[2*k +: 2];
      case (quad)
        hpd_pkg::QUAD_LL: begin
          nx = y;
          ny = x;
        end
        hpd_pkg::QUAD_UL: begin
          nx = x;
          ny = y + half;
        end
        hpd_pkg::QUAD_UR: begin
          nx = x + half;
          ny = y + half;
        end
        default: begin
          nx = 2 * half - 1 - y;
          ny = half - 1 - x;
        end
      endcase
      x = nx;
      y = ny;
    end
    px = x;
    py = y;
  endfunction

  function automatic logic [63:0] rounded_root(input logic [63:0] m);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = hpd_pkg::ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= m) begin
        r = t;
      end
    end
    if (m > r * r + r) begin
      r = r + 1;
    end
    return r;
  endfunction

  function automatic hpd_pkg::hpd_out_t pair_geometry(input hpd_pkg::hpd_in_t req);
    hpd_pkg::hpd_out_t res;
    int unsigned n;
    logic [63:0] span;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] x1;
    logic [63:0] y1;
    logic [63:0] x2;
    logic [63:0] y2;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] dist_full;
    res = '0;
    n = 32'(req.order);
    if (n > hpd_pkg::MAX_ORDER) begin
      n = hpd_pkg::MAX_ORDER;
    end
    span = 64'd1 << (2 * n);
    p1 = {31'd0, req.first_index};
    p2 = {31'd0, req.second_index};
    if (p1 == 0 || p1 - 1 >= span || p2 == 0 || p2 - 1 >= span) begin
      res.range_error = 1'b1;
      return res;
    end
    curve_point(p1 - 1, n, x1, y1);
    curve_point(p2 - 1, n, x2, y2);
    dx = (x1 >= x2) ? x1 - x2 : x2 - x1;
    dy = (y1 >= y2) ? y1 - y2 : y2 - y1;
    res.first_x = x1[hpd_pkg::COORD_W-1:0];
    res.first_y = y1[hpd_pkg::COORD_W-1:0];
    res.second_x = x2[hpd_pkg::COORD_W-1:0];
    res.second_y = y2[hpd_pkg::COORD_W-1:0];
    dist_full = rounded_root(hpd_pkg::SCALE * (dx * dx + dy * dy));
    res.scaled_distance = dist_full[hpd_pkg::DIST_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // predict on each accepted request, compare each taken result
  always @(posedge clk) begin
    hpd_pkg::hpd_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_geometry.push_back(pair_geometry(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_geometry.size() == 0) begin
          $display("%0t unexpected result %h, no request pending", $time, out_data);
          error_count++;
        end else begin
          want = pending_geometry.pop_front();
          check_field("first_x", 32'(want.first_x), 32'(out_data.first_x));
          check_field("first_y", 32'(want.first_y), 32'(out_data.first_y));
          check_field("second_x", 32'(want.second_x), 32'(out_data.second_x));
          check_field("second_y", 32'(want.second_y), 32'(out_data.second_y));
          check_field("scaled_distance", 32'(want.scaled_distance),
                      32'(out_data.scaled_distance));
          check_field("range_error", 32'(want.range_error), 32'(out_data.range_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_geometry.size());
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off, started by a bump of hold_seq
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_seq;
    end
  end

  always @(posedge clk) begin
    logic ready_bit;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: ready_bit = 1'b1;
        READY_COIN:   ready_bit = ($urandom_range(0, 1) != 0);
        READY_BURSTY: ready_bit = (mode_left % 7) < 3;
        default:      ready_bit = ($urandom_range(0, 9) != 0);
      endcase
      out_ready <= ready_bit && (hold_left == 0);
    end
  end

  task automatic send_request(input hpd_pkg::hpd_in_t req);
    int unsigned gap;
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 15);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_indices(input logic [hpd_pkg::ORDER_W-1:0] ord,
                              input logic [hpd_pkg::IDX_W-1:0] a,
                              input logic [hpd_pkg::IDX_W-1:0] b);
    hpd_pkg::hpd_in_t req;
    req.order = ord;
    req.first_index = a;
    req.second_index = b;
    send_request(req);
  endtask

  function automatic hpd_pkg::hpd_in_t random_request();
    hpd_pkg::hpd_in_t req;
    int unsigned n;
    int unsigned pick;
    logic [63:0] span;
    logic [63:0] a;
    logic [63:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req.order = hpd_pkg::ORDER_W'($urandom);
      req.first_index = hpd_pkg::IDX_W'({$urandom, $urandom});
      req.second_index = hpd_pkg::IDX_W'({$urandom, $urandom});
      return req;
    end
    req.order = (pick < 18) ? hpd_pkg::ORDER_W'($urandom_range(0, 31)) :
                              hpd_pkg::ORDER_W'($urandom_range(1, hpd_pkg::MAX_ORDER));
    n = (req.order > hpd_pkg::MAX_ORDER) ? hpd_pkg::MAX_ORDER : 32'(req.order);
    span = 64'd1 << (2 * n);
    a = 1 + ({$urandom, $urandom} % span);
    if ($urandom_range(0, 9) < 4) begin
      b = a + $urandom_range(0, 40);
      if (b > span) begin
        b = span;
      end
    end else begin
      b = 1 + ({$urandom, $urandom} % span);
    end
    // broken indices just past either end of the curve
    if (pick >= 18 && pick < 24) begin
      case ($urandom_range(0, 3))
        0:       a = 0;
        1:       b = 0;
        2:       a = span + 1;
        default: b = span + $urandom_range(1, 3);
      endcase
    end
    req.first_index = a[hpd_pkg::IDX_W-1:0];
    req.second_index = b[hpd_pkg::IDX_W-1:0];
    return req;
  endfunction

  task automatic test_directed_corners();
    send_indices(5'd1, 33'd1, 33'd4);
    send_indices(5'd1, 33'd2, 33'd3);
    send_indices(5'd1, 33'd4, 33'd1);
    send_indices(5'd2, 33'd1, 33'd16);
    send_indices(5'd16, 33'd1, 33'h1_0000_0000);
    send_indices(5'd16, 33'h1_0000_0000, 33'h0_8000_0001);
    send_indices(5'd16, 33'd12345678, 33'd12345678);
    send_indices(5'd16, 33'h0_AAAA_AAAB, 33'h0_5555_5555);
    send_indices(5'd0, 33'd1, 33'd1);
    send_indices(5'd0, 33'd1, 33'd2);
    send_indices(5'd0, 33'd0, 33'd0);
    send_indices(5'd3, 33'd64, 33'd1);
    send_indices(5'd3, 33'd65, 33'd1);
    send_indices(5'd3, 33'd1, 33'd65);
    send_indices(5'd5, 33'd0, 33'd3);
    send_indices(5'd5, 33'd3, 33'd0);
    send_indices(5'd17, 33'h1_0000_0000, 33'd1);
    send_indices(5'd31, 33'h1_FFFF_FFFF, 33'd1);
    send_indices(5'd31, 33'd7, 33'h1_0000_0001);
    send_indices(5'd8, 33'd100, 33'd40000);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 250 == 0) begin
        gaps_on = (i % 750) != 500;
      end
      send_request(random_request());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure_fill();
    gaps_on = 1'b0;
    hold_seq <= hold_seq + 1;
    repeat (160) send_request(random_request());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_traffic();
    test_backpressure_fill();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_geometry.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
